// ----- sv/octahedral_normal_encoder_unit_macros.svh -----
// Assertion macros shared by the encoder checker.
`ifndef OCTAHEDRAL_NORMAL_ENCODER_UNIT_MACROS_SVH
`define OCTAHEDRAL_NORMAL_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OCT_ENC_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OCT_ENC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Next-cycle implication that also covers reset itself.
`define OCT_ENC_ASSERT_RESET(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ----- sv/oct_enc_pkg.sv -----
// Shared types and constants of the octahedral normal encoder.
package oct_enc_pkg;

  localparam int OCT_BITS     = 16;
  localparam int DIV_STEPS    = 4;
  localparam int DIV_STAGES   = OCT_BITS / DIV_STEPS;
  localparam int FRONT_STAGES = 3;

  typedef logic [OCT_BITS-1:0] oct_word_t;

  localparam oct_word_t ZERO_CODE = oct_word_t'(32768);

endpackage

// ----- sv/oct_enc_div_step.sv -----
// DIV_STEPS restoring division steps for one encoder lane.
module oct_enc_div_step
  import oct_enc_pkg::*;
#(
  parameter int RW = 18
) (
  input  logic [RW-1:0] rem,
  input  oct_word_t     lo,
  input  logic [RW-1:0] den,
  output logic [RW-1:0] rem_next,
  output oct_word_t     lo_next
);

  always_comb begin
    logic [RW:0] t;
    logic [RW-1:0] r;
    oct_word_t l;
    r = rem;
    l = lo;
    for (int i = 0; i < DIV_STEPS; i++) begin
      // Bring down the next dividend bit; quotient bit enters at the bottom.
      t = {r, l[OCT_BITS-1]};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        l = {l[OCT_BITS-2:0], 1'b1};
      end else begin
        l = {l[OCT_BITS-2:0], 1'b0};
      end
      r = t[RW-1:0];
    end
    rem_next = r;
    lo_next  = l;
  end

endmodule

// ----- sv/octahedral_normal_encoder_unit.sv -----
// Octahedral normal encoder: signed (x, y, z) vector in, two 16-bit words out.
//
// One request per clock while nothing stalls, fully pipelined: a request
// carries normal_x/y/z, returns oct_u/oct_v through 3 + 16/4 = 7 register stages.
// The depth is set by the exact 16-bit quotient floor(N / 2d), computed by a
// restoring divider that retires 4 quotient bits in each of 4 stages; three
// front stages take absolute values, form the L1 norm d with the fold, and
// build the dividend. Each stage holds only while it is full and the stage
// after it holds, so bubbles collapse and a stalled output still lets new
// requests fill the empty stages behind it. A zero vector returns 32768 in
// both words. No configuration, no state kept between requests.
module octahedral_normal_encoder_unit
  import oct_enc_pkg::*;
#(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             normal_valid,
  output logic                             normal_stall,
  input  logic signed [COMPONENT_BITS-1:0] normal_x,
  input  logic signed [COMPONENT_BITS-1:0] normal_y,
  input  logic signed [COMPONENT_BITS-1:0] normal_z,
  output logic                             oct_valid,
  input  logic                             oct_stall,
  output oct_word_t                        oct_u,
  output oct_word_t                        oct_v
);

  // Magnitudes fit COMPONENT_BITS, d fits one more bit, signed numerators
  // and the doubled divisor one more again.
  localparam int AW  = COMPONENT_BITS;
  localparam int DW  = COMPONENT_BITS + 1;
  localparam int RW  = COMPONENT_BITS + 2;
  localparam int NW  = RW + OCT_BITS;
  localparam int NST = FRONT_STAGES + DIV_STAGES;

  logic [NST-1:0] vld;
  logic [NST:0]   adv;

  // Advance a stage when it is empty or the stage after it advances.
  always_comb begin
    adv[NST] = !oct_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign normal_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= normal_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: take magnitudes and signs.
  logic [AW-1:0] s1_ax, s1_ay, s1_az;
  logic          s1_xneg, s1_yneg, s1_zneg;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_xneg <= normal_x[AW-1];
      s1_yneg <= normal_y[AW-1];
      s1_zneg <= normal_z[AW-1];
      s1_ax   <= normal_x[AW-1] ? (~normal_x + 1'b1) : normal_x;
      s1_ay   <= normal_y[AW-1] ? (~normal_y + 1'b1) : normal_y;
      s1_az   <= normal_z[AW-1] ? (~normal_z + 1'b1) : normal_z;
    end
  end

  // Stage 2: form d and the folded numerators. Under the fold, d - |y| is
  // simply |x| + |z| (and likewise for v); sign(0) counts as positive.
  logic [DW-1:0] s2_d;
  logic [RW-1:0] s2_nu, s2_nv;
  logic [DW-1:0] mag_u, mag_v;

  always_comb begin
    if (s1_zneg) begin
      mag_u = {1'b0, s1_ax} + {1'b0, s1_az};
      mag_v = {1'b0, s1_ay} + {1'b0, s1_az};
    end else begin
      mag_u = {1'b0, s1_ax};
      mag_v = {1'b0, s1_ay};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_d  <= {1'b0, s1_ax} + {1'b0, s1_ay} + {1'b0, s1_az};
      s2_nu <= s1_xneg ? (~{1'b0, mag_u} + 1'b1) : {1'b0, mag_u};
      s2_nv <= s1_yneg ? (~{1'b0, mag_v} + 1'b1) : {1'b0, mag_v};
    end
  end

  // Stage 3: build the dividend N = (a + d) * 65535 + d, written as
  // ((a + d) << 16) + d - (a + d), and the divisor 2d.
  logic [RW-1:0] dv_rem_u [DIV_STAGES+1];
  logic [RW-1:0] dv_rem_v [DIV_STAGES+1];
  oct_word_t     dv_lo_u  [DIV_STAGES+1];
  oct_word_t     dv_lo_v  [DIV_STAGES+1];
  logic [RW-1:0] dv_den   [DIV_STAGES+1];
  logic          dv_zero  [DIV_STAGES+1];

  logic [RW-1:0] sh_u, sh_v;
  logic [NW-1:0] num_u, num_v;

  always_comb begin
    sh_u  = s2_nu + {1'b0, s2_d};
    sh_v  = s2_nv + {1'b0, s2_d};
    num_u = {sh_u, {OCT_BITS{1'b0}}} + NW'(s2_d) - NW'(sh_u);
    num_v = {sh_v, {OCT_BITS{1'b0}}} + NW'(s2_d) - NW'(sh_v);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      dv_rem_u[0] <= num_u[NW-1:OCT_BITS];
      dv_lo_u[0]  <= num_u[OCT_BITS-1:0];
      dv_rem_v[0] <= num_v[NW-1:OCT_BITS];
      dv_lo_v[0]  <= num_v[OCT_BITS-1:0];
      dv_den[0]   <= {s2_d, 1'b0};
      dv_zero[0]  <= (s2_d == '0);
    end
  end

  // Divider stages: each retires DIV_STEPS quotient bits per lane.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [RW-1:0] rem_u_next, rem_v_next;
    oct_word_t     lo_u_next, lo_v_next;

    oct_enc_div_step #(.RW(RW)) u_step_u (
      .rem      (dv_rem_u[k]),
      .lo       (dv_lo_u[k]),
      .den      (dv_den[k]),
      .rem_next (rem_u_next),
      .lo_next  (lo_u_next)
    );

    oct_enc_div_step #(.RW(RW)) u_step_v (
      .rem      (dv_rem_v[k]),
      .lo       (dv_lo_v[k]),
      .den      (dv_den[k]),
      .rem_next (rem_v_next),
      .lo_next  (lo_v_next)
    );

    always_ff @(posedge clk) begin
      if (adv[FRONT_STAGES+k]) begin
        dv_rem_u[k+1] <= rem_u_next;
        dv_lo_u[k+1]  <= lo_u_next;
        dv_rem_v[k+1] <= rem_v_next;
        dv_lo_v[k+1]  <= lo_v_next;
        dv_den[k+1]   <= dv_den[k];
        dv_zero[k+1]  <= dv_zero[k];
      end
    end
  end

  // After the last stage the low words hold the quotients; the final
  // remainders are not needed. Drop the quotient for a zero vector.
  assign oct_valid = vld[NST-1];
  assign oct_u     = dv_zero[DIV_STAGES] ? ZERO_CODE : dv_lo_u[DIV_STAGES];
  assign oct_v     = dv_zero[DIV_STAGES] ? ZERO_CODE : dv_lo_v[DIV_STAGES];

endmodule

// ----- sv/oct_enc_checker.sv -----
// Port-level checker for the octahedral normal encoder, with its bind.
`include "octahedral_normal_encoder_unit_macros.svh"

module oct_enc_checker
  import oct_enc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      normal_valid,
  input logic      normal_stall,
  input logic      oct_valid,
  input logic      oct_stall,
  input oct_word_t oct_u,
  input oct_word_t oct_v
);

  // Reset empties the pipeline.
  `OCT_ENC_ASSERT_RESET(a_reset_empty, rst, !oct_valid, "result valid after reset")

  // A free or empty output end lets every stage advance.
  `OCT_ENC_ASSERT_NOW(a_no_false_stall, (!oct_valid || !oct_stall) && normal_valid,
    !normal_stall, "request stalled while pipeline can advance")

  // A stalled result stays offered.
  `OCT_ENC_ASSERT_NEXT(a_result_held, oct_valid && oct_stall, oct_valid,
    "result dropped under stall")

  // A stalled result keeps its value.
  `OCT_ENC_ASSERT_NEXT(a_result_stable, oct_valid && oct_stall,
    $stable(oct_u) && $stable(oct_v), "result changed under stall")

endmodule

bind octahedral_normal_encoder_unit oct_enc_checker u_oct_enc_checker (.*);

// ----- test/octahedral_normal_encoder_unit_tb.sv -----
// Self-checking testbench of the octahedral normal encoder with its own encoding predictor.
module octahedral_normal_encoder_unit_tb;
  import oct_enc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COMP_BITS    = 16;
  localparam int RANDOM_REQS  = 450;
  localparam int IDLE_PERCENT = 28;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [COMP_BITS-1:0] comp_t;

  // One request as the sender offers it. Rows whose codes can be read off directly
  // carry them in u/v with typed_exp set; all other rows go through the predictor.
  typedef struct packed {
    comp_t     x;
    comp_t     y;
    comp_t     z;
    logic      typed_exp;
    oct_word_t u;
    oct_word_t v;
  } normal_req_t;

  typedef struct packed {
    oct_word_t u;
    oct_word_t v;
  } oct_pair_t;

  typedef enum logic [1:0] {STYLE_FULL, STYLE_SMALL, STYLE_EDGE} comp_style_t;

  localparam comp_t EDGE_VALUES [5] = '{-32768, -1, 0, 1, 32767};

  // Directed table: extremes, the zero vector, both hemispheres, and zero
  // components under the fold (sign of zero counts as positive).
  localparam int NUM_DIRECTED = 24;
  localparam normal_req_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{0,           0,           0,      1'b1, 32768, 32768},  // zero vector
    '{32767,       0,           0,      1'b1, 65535, 32768},
    '{-32768,      0,           0,      1'b1, 0,     32768},
    '{0,           32767,       0,      1'b1, 32768, 65535},
    '{0,           -32768,      0,      1'b1, 32768, 0},
    '{0,           0,           32767,  1'b1, 32768, 32768},
    '{0,           0,           -32768, 1'b1, 65535, 65535},  // fold, both zero
    '{0,           0,           -1,     1'b1, 65535, 65535},
    '{0,           0,           1,      1'b1, 32768, 32768},
    '{1,           0,           0,      1'b1, 65535, 32768},
    '{-1,          0,           0,      1'b1, 0,     32768},
    '{-32768,      -32768,      -32768, 1'b0, 0,     0},
    '{32767,       32767,       32767,  1'b0, 0,     0},
    '{-1,          -1,          -1,     1'b0, 0,     0},
    '{1,           1,           1,      1'b0, 0,     0},
    '{-5,          0,           -3,     1'b0, 0,     0},      // fold, y zero
    '{0,           -5,          -3,     1'b0, 0,     0},      // fold, x zero
    '{7,           -9,          -2,     1'b0, 0,     0},
    '{-7,          9,           -2,     1'b0, 0,     0},
    '{32767,       -32768,      -1,     1'b0, 0,     0},
    '{-32768,      32767,       1,      1'b0, 0,     0},
    '{-32768,      -32768,      0,      1'b0, 0,     0},
    '{16'sh5555,   16'shAAAA,   -5,     1'b0, 0,     0},
    '{16'shAAAA,   16'sh5555,   16'sh7FFF, 1'b0, 0,  0}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      normal_valid = 1'b0;
  logic      normal_stall;
  comp_t     normal_x = '0;
  comp_t     normal_y = '0;
  comp_t     normal_z = '0;
  logic      oct_valid;
  logic      oct_stall = 1'b0;
  oct_word_t oct_u;
  oct_word_t oct_v;

  logic      hold_off = 1'b0;

  normal_req_t normal_reqs [$];
  oct_pair_t   pending_codes [$];
  oct_pair_t   want_codes;
  int          send_idx = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  octahedral_normal_encoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .normal_valid (normal_valid),
    .normal_stall (normal_stall),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .oct_valid    (oct_valid),
    .oct_stall    (oct_stall),
    .oct_u        (oct_u),
    .oct_v        (oct_v)
  );

  always #5ns clk = ~clk;

  // Round-half-up packing of s = a / d into a 16-bit code, exact in integers.
  function automatic oct_word_t pack_coord(longint a, longint d);
    longint num;
    num = (a + d) * 65535 + d;
    return oct_word_t'(num / (2 * d));
  endfunction

  // Predict both codes of one normal: L1 projection, then the lower-hemisphere
  // fold when z is negative.
  function automatic oct_pair_t encode_normal(comp_t x, comp_t y, comp_t z);
    longint    sx, sy, sz, ax, ay, d, nu, nv;
    oct_pair_t codes;
    sx = x;
    sy = y;
    sz = z;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    d  = ax + ay + ((sz < 0) ? -sz : sz);
    if (d == 0) begin
      codes.u = ZERO_CODE;
      codes.v = ZERO_CODE;
      return codes;
    end
    nu = sx;
    nv = sy;
    if (sz < 0) begin
      nu = (sx >= 0) ? (d - ay) : -(d - ay);
      nv = (sy >= 0) ? (d - ax) : -(d - ax);
    end
    codes.u = pack_coord(nu, d);
    codes.v = pack_coord(nv, d);
    return codes;
  endfunction

  function automatic comp_t random_component(comp_style_t style);
    case (style)
      STYLE_FULL:  return comp_t'($urandom_range(65535));
      STYLE_SMALL: return comp_t'(int'($urandom_range(64)) - 32);
      default:     return EDGE_VALUES[$urandom_range(4)];
    endcase
  endfunction

  task automatic note_mismatch(string what, oct_pair_t want, oct_word_t got_u,
                               oct_word_t got_v);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch (%s) at result %0d: expected u=%0d v=%0d, got u=%0d v=%0d",
               what, results_seen, want.u, want.v, got_u, got_v);
  endtask

  // Sender: hold the payload while stalled, advance on acceptance, and idle
  // at random except during a no-idle stretch in the middle of the random part.
  always @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else begin
      if (normal_valid && !normal_stall) begin
        if (normal_reqs[send_idx].typed_exp)
          pending_codes.push_back({normal_reqs[send_idx].u, normal_reqs[send_idx].v});
        else
          pending_codes.push_back(encode_normal(normal_reqs[send_idx].x,
                                                normal_reqs[send_idx].y,
                                                normal_reqs[send_idx].z));
        send_idx++;
      end
      if (!normal_valid || !normal_stall) begin
        if (send_idx < normal_reqs.size() &&
            ((send_idx >= 250 && send_idx < 350) ||
             $urandom_range(99) >= IDLE_PERCENT)) begin
          normal_x     <= normal_reqs[send_idx].x;
          normal_y     <= normal_reqs[send_idx].y;
          normal_z     <= normal_reqs[send_idx].z;
          normal_valid <= 1'b1;
        end else begin
          normal_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each accepted result with the oldest pending codes, then
  // pick the stall for the next cycle. The long hold-off overrides everything.
  always @(posedge clk) begin
    if (rst) begin
      oct_stall <= 1'b0;
    end else begin
      if (oct_valid && !oct_stall) begin
        if (pending_codes.size() == 0) begin
          note_mismatch("no request pending", '0, oct_u, oct_v);
        end else begin
          want_codes = pending_codes.pop_front();
          if (oct_u !== want_codes.u || oct_v !== want_codes.v)
            note_mismatch("wrong code", want_codes, oct_u, oct_v);
        end
        results_seen++;
      end
      oct_stall <= hold_off ||
                   (!(results_seen >= 250 && results_seen < 350) &&
                    $urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Long back-pressure: stop draining for a while so the pipeline fills and
  // the block has to stall incoming requests.
  initial begin
    wait (results_seen >= 80);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    normal_req_t   row;
    comp_t         comps [3];
    int unsigned   pick;
    int unsigned   big;
    comp_style_t   style;

    // Build the whole request list up front: directed table, then random mix
    // of full-range, small-magnitude, one-dominant and edge-value vectors.
    foreach (DIRECTED_ROWS[i])
      normal_reqs.push_back(DIRECTED_ROWS[i]);
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(9);
      big  = $urandom_range(2);
      for (int c = 0; c < 3; c++) begin
        if (pick < 5)
          style = STYLE_FULL;
        else if (pick < 7)
          style = STYLE_SMALL;
        else if (pick < 9)
          style = (c == big) ? STYLE_FULL : STYLE_SMALL;
        else
          style = STYLE_EDGE;
        comps[c] = random_component(style);
      end
      row = '0;
      row.x = comps[0];
      row.y = comps[1];
      row.z = comps[2];
      normal_reqs.push_back(row);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken, then for every result to arrive,
    // then let the pipeline run empty to catch stray results.
    while (send_idx < normal_reqs.size()) @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/oct_enc_pkg.sv
sv/oct_enc_div_step.sv
sv/octahedral_normal_encoder_unit.sv
sv/oct_enc_checker.sv
test/octahedral_normal_encoder_unit_tb.sv
